>>> rtl/core/cssc_pkg.sv
// Shared constants and types of the CSS color function to RGBA converter.
package cssc_pkg;

   localparam int ArgW  = 20;
   localparam int OutW  = 13;
   localparam int FracW = 14;
   localparam int HueW  = 17;

   localparam logic [OutW-1:0] OneQ12  = 13'd4096;
   localparam logic [OutW-1:0] HalfQ12 = 13'd2048;

   localparam logic signed [ArgW-1:0] PctClip  = 20'sd25603;
   localparam logic signed [ArgW-1:0] ByteClip = 20'sd65287;
   localparam logic signed [ArgW-1:0] RawClip  = 20'sd255;

   localparam logic [22:0] PctBias  = 23'd12;
   localparam logic [22:0] ByteBias = 23'd127;
   localparam logic [23:0] PctRecip  = 24'd10737419;
   localparam logic [23:0] ByteRecip = 24'd1052689;
   localparam int RecipShift = 28;

   localparam logic [20:0] HueBias    = 21'd552960;
   localparam logic [14:0] BlockRecip = 15'd23302;
   localparam int BlockShift = 21;
   localparam logic [10:0] BlockDeg   = 11'd90;

   localparam logic [HueW-1:0] Sixth     = 17'd15360;
   localparam logic [HueW-1:0] Third     = 17'd30720;
   localparam logic [HueW-1:0] HalfTurn  = 17'd46080;
   localparam logic [HueW-1:0] TwoThirds = 17'd61440;

   localparam logic [25:0] LerpRound    = 26'd7680;
   localparam logic [16:0] FifteenRecip = 17'd69906;
   localparam int FifteenShift = 20;

   typedef enum logic [1:0] {
      SCALE_BYTE,
      SCALE_PCT,
      SCALE_RAW,
      SCALE_ONE
   } scale_type;

   typedef enum logic [1:0] {
      SEG_RISE,
      SEG_HIGH,
      SEG_FALL,
      SEG_LOW
   } seg_type;

   typedef struct packed {
      seg_type          seg;
      logic [FracW-1:0] frac;
   } hue_pos_type;

   typedef struct packed {
      logic a;
      logic b;
      logic c;
      logic d;
      logic e;
      logic f;
      logic g;
   } pipe_en_type;

   typedef struct packed {
      logic            hsl;
      logic [OutW-1:0] red;
      logic [OutW-1:0] green;
      logic [OutW-1:0] blue;
      logic [OutW-1:0] alpha;
   } side_type;

endpackage

>>> rtl/core/cssc_if.sv
// Request and response channel interfaces of the color function converter.
interface cssc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              mode;
   logic signed [cssc_pkg::ArgW-1:0]  first_value;
   logic signed [cssc_pkg::ArgW-1:0]  second_value;
   logic signed [cssc_pkg::ArgW-1:0]  third_value;
   logic signed [cssc_pkg::ArgW-1:0]  alpha_value;
   logic                              first_is_percent;
   logic                              second_is_percent;
   logic                              third_is_percent;
   logic                              alpha_is_percent;
   logic                              alpha_given;

   modport source (
      output valid, mode, first_value, second_value, third_value, alpha_value,
             first_is_percent, second_is_percent, third_is_percent,
             alpha_is_percent, alpha_given,
      input  ready
   );

   modport sink (
      input  valid, mode, first_value, second_value, third_value, alpha_value,
             first_is_percent, second_is_percent, third_is_percent,
             alpha_is_percent, alpha_given,
      output ready
   );
endinterface

interface cssc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cssc_pkg::OutW-1:0]  red_out;
   logic [cssc_pkg::OutW-1:0]  green_out;
   logic [cssc_pkg::OutW-1:0]  blue_out;
   logic [cssc_pkg::OutW-1:0]  alpha_out;

   modport source (
      output valid, red_out, green_out, blue_out, alpha_out,
      input  ready
   );

   modport sink (
      input  valid, red_out, green_out, blue_out, alpha_out,
      output ready
   );
endinterface

>>> rtl/core/css_color_function_to_rgba.sv
// Top level of the CSS rgb()/hsl() argument to normalized RGBA converter.
//
// req_ch carries one color function call per transfer: mode (rgb or hsl),
// three Q.8 arguments with percent flags, and an optional Q.8 alpha.
// rsp_ch returns red, green, blue and alpha as Q.12 values in 0..4096,
// one response transfer per request transfer, in order.
//
// Throughput: one transfer per cycle while rsp_ch accepts responses. The
// datapath has seven register stages (argument scaling by reciprocal
// multiply alongside the hue wrap, the lightness product, the p/q terms,
// the two multiplies of the hue interpolation, and the output select).
//
// Each stage holds only while the stage after it is full and stalled, so
// bubbles close up and requests keep flowing while a finished response
// waits on rsp_ch. req_ch.ready drops only when all seven stages are full.
// Reset clears all stage valid bits; no response is pending after reset.
module css_color_function_to_rgba (
   input  logic        clock,
   input  logic        reset,
   cssc_req_if.sink    req_ch,
   cssc_rsp_if.source  rsp_ch
);
   import cssc_pkg::*;

   localparam int Stages = 7;

   logic [Stages-1:0]  vld_ff;
   logic [Stages-1:0]  adv;
   pipe_en_type        en;

   scale_type          sc_first;
   scale_type          sc_second;
   scale_type          sc_third;
   scale_type          sc_alpha;
   logic [OutW-1:0]    r_q;
   logic [OutW-1:0]    g_q;
   logic [OutW-1:0]    b_q;
   logic [OutW-1:0]    a_q;

   logic               mode_a_ff;
   logic               mode_b_ff;
   side_type           side_in;
   side_type [3:0]     side_ff;
   logic [OutW-1:0]    alpha_ff;

   logic [OutW-1:0]    hp;
   logic [OutW-1:0]    hq;
   logic [OutW-1:0]    hd;
   hue_pos_type [2:0]  hpos;
   logic [2:0][OutW-1:0] chan;

   always_comb begin
      adv[Stages-1] = !vld_ff[Stages-1] || rsp_ch.ready;
      for (int k = Stages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign en = '{a: adv[0], b: adv[1], c: adv[2], d: adv[3],
                 e: adv[4], f: adv[5], g: adv[6]};

   assign req_ch.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= (k == 0) ? req_ch.valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // hsl forces percent scaling of saturation and lightness
   always_comb begin
      sc_first  = req_ch.first_is_percent ? SCALE_PCT : SCALE_BYTE;
      sc_second = (req_ch.mode || req_ch.second_is_percent) ? SCALE_PCT : SCALE_BYTE;
      sc_third  = (req_ch.mode || req_ch.third_is_percent) ? SCALE_PCT : SCALE_BYTE;
      priority if (!req_ch.alpha_given)    sc_alpha = SCALE_ONE;
      else if (req_ch.alpha_is_percent)    sc_alpha = SCALE_PCT;
      else                                 sc_alpha = SCALE_RAW;
   end

   cssc_arg_scale u_scale_first (
      .clock  (clock),
      .en     (en),
      .scale  (sc_first),
      .value  (req_ch.first_value),
      .scaled (r_q)
   );

   cssc_arg_scale u_scale_second (
      .clock  (clock),
      .en     (en),
      .scale  (sc_second),
      .value  (req_ch.second_value),
      .scaled (g_q)
   );

   cssc_arg_scale u_scale_third (
      .clock  (clock),
      .en     (en),
      .scale  (sc_third),
      .value  (req_ch.third_value),
      .scaled (b_q)
   );

   cssc_arg_scale u_scale_alpha (
      .clock  (clock),
      .en     (en),
      .scale  (sc_alpha),
      .value  (req_ch.alpha_value),
      .scaled (a_q)
   );

   cssc_hsl_prep u_hsl_prep (
      .clock     (clock),
      .en        (en),
      .hue       (req_ch.first_value),
      .sat_q12   (g_q),
      .light_q12 (b_q),
      .p         (hp),
      .q         (hq),
      .d         (hd),
      .pos       (hpos)
   );

   assign side_in = '{hsl: mode_b_ff, red: r_q, green: g_q, blue: b_q, alpha: a_q};

   always_ff @(posedge clock) begin
      if (en.a) mode_a_ff <= req_ch.mode;
      if (en.b) mode_b_ff <= mode_a_ff;
      if (en.c) side_ff[0] <= side_in;
      if (en.d) side_ff[1] <= side_ff[0];
      if (en.e) side_ff[2] <= side_ff[1];
      if (en.f) side_ff[3] <= side_ff[2];
      if (en.g) alpha_ff <= side_ff[3].alpha;
   end

   cssc_hue_lerp u_lerp_red (
      .clock (clock),
      .en    (en),
      .p     (hp),
      .q     (hq),
      .d     (hd),
      .pos   (hpos[0]),
      .hsl   (side_ff[3].hsl),
      .rgb   (side_ff[3].red),
      .value (chan[0])
   );

   cssc_hue_lerp u_lerp_green (
      .clock (clock),
      .en    (en),
      .p     (hp),
      .q     (hq),
      .d     (hd),
      .pos   (hpos[1]),
      .hsl   (side_ff[3].hsl),
      .rgb   (side_ff[3].green),
      .value (chan[1])
   );

   cssc_hue_lerp u_lerp_blue (
      .clock (clock),
      .en    (en),
      .p     (hp),
      .q     (hq),
      .d     (hd),
      .pos   (hpos[2]),
      .hsl   (side_ff[3].hsl),
      .rgb   (side_ff[3].blue),
      .value (chan[2])
   );

   assign rsp_ch.valid     = vld_ff[Stages-1];
   assign rsp_ch.red_out   = chan[0];
   assign rsp_ch.green_out = chan[1];
   assign rsp_ch.blue_out  = chan[2];
   assign rsp_ch.alpha_out = alpha_ff;

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (&vld_ff))
      else $error("request stalled with a bubble in the pipeline");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> (vld_ff == '0))
      else $error("stage valid bits not cleared by reset");

   a_pq_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (hq >= hp))
      else $error("hsl q term below p term");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.red_out <= OneQ12) && (rsp_ch.green_out <= OneQ12) &&
                       (rsp_ch.blue_out <= OneQ12) && (rsp_ch.alpha_out <= OneQ12))
      else $error("response channel above unit range");

endmodule

>>> rtl/core/cssc_arg_scale.sv
// Two-stage scaling of one Q.8 argument to a clamped Q.12 unit value.
module cssc_arg_scale (
   input  logic                              clock,
   input  cssc_pkg::pipe_en_type             en,
   input  cssc_pkg::scale_type               scale,
   input  logic signed [cssc_pkg::ArgW-1:0]  value,
   output logic [cssc_pkg::OutW-1:0]         scaled
);
   import cssc_pkg::*;

   logic             nonpos;
   logic             sat;
   logic [22:0]      num_wide;
   logic [ArgW-1:0]  num;
   logic [23:0]      recip;
   logic [43:0]      prod;
   logic [OutW-1:0]  scaled_in;

   logic [OutW-1:0]  quot_ff;
   logic [11:0]      raw_ff;
   logic             nonpos_ff;
   logic             sat_ff;
   scale_type        scale_ff;
   logic [OutW-1:0]  scaled_ff;

   always_comb begin
      nonpos = value[ArgW-1] || (value == '0);
      unique case (scale)
         SCALE_PCT: begin
            sat      = value > PctClip;
            num_wide = {2'b00, value[18:0], 2'b00} + PctBias;
         end
         SCALE_BYTE: begin
            sat      = value > ByteClip;
            num_wide = {value[18:0], 4'b0000} + ByteBias;
         end
         SCALE_RAW: begin
            sat      = value > RawClip;
            num_wide = '0;
         end
         SCALE_ONE: begin
            sat      = 1'b1;
            num_wide = '0;
         end
      endcase
      num   = num_wide[ArgW-1:0];
      recip = (scale == SCALE_PCT) ? PctRecip : ByteRecip;
      prod  = {24'b0, num} * {20'b0, recip};
   end

   always_comb begin
      priority if (scale_ff == SCALE_ONE) scaled_in = OneQ12;
      else if (nonpos_ff)                 scaled_in = '0;
      else if (sat_ff)                    scaled_in = OneQ12;
      else if (scale_ff == SCALE_RAW)     scaled_in = {1'b0, raw_ff};
      else                                scaled_in = quot_ff;
   end

   always_ff @(posedge clock) begin
      if (en.a) begin
         quot_ff   <= prod[RecipShift +: OutW];
         raw_ff    <= {value[7:0], 4'b0000};
         nonpos_ff <= nonpos;
         sat_ff    <= sat;
         scale_ff  <= scale;
      end
      if (en.b) begin
         scaled_ff <= scaled_in;
      end
   end

   assign scaled = scaled_ff;

endmodule

>>> rtl/core/cssc_hsl_prep.sv
// Hue wrap, HSL p/q terms and per-channel hue segment over four stages.
module cssc_hsl_prep (
   input  logic                              clock,
   input  cssc_pkg::pipe_en_type             en,
   input  logic signed [cssc_pkg::ArgW-1:0]  hue,
   input  logic [cssc_pkg::OutW-1:0]         sat_q12,
   input  logic [cssc_pkg::OutW-1:0]         light_q12,
   output logic [cssc_pkg::OutW-1:0]         p,
   output logic [cssc_pkg::OutW-1:0]         q,
   output logic [cssc_pkg::OutW-1:0]         d,
   output cssc_pkg::hue_pos_type [2:0]       pos
);
   import cssc_pkg::*;

   function automatic hue_pos_type locate(input logic [HueW-1:0] t);
      hue_pos_type      r;
      logic [HueW-1:0]  fall;
      fall   = TwoThirds - t;
      r.frac = '0;
      priority if (t < Sixth) begin
         r.seg  = SEG_RISE;
         r.frac = t[FracW-1:0];
      end else if (t < HalfTurn) begin
         r.seg = SEG_HIGH;
      end else if (t < TwoThirds) begin
         r.seg  = SEG_FALL;
         r.frac = fall[FracW-1:0];
      end else begin
         r.seg = SEG_LOW;
      end
      return r;
   endfunction

   logic [20:0]      biased;
   logic [25:0]      bprod;
   logic [10:0]      rem_w;
   logic [HueW-1:0]  h_in;
   logic             big;
   logic [13:0]      mfac;
   logic [26:0]      ml;
   logic [26:0]      rnd_w;
   logic [14:0]      rnd;
   logic [14:0]      q_w;
   logic [OutW-1:0]  q_in;
   logic [13:0]      p_w;
   logic [OutW-1:0]  p_in;
   logic [OutW-1:0]  d_in;
   logic [2:0][HueW-1:0] tch;
   hue_pos_type [2:0] pos_in;

   logic [10:0]      blk_ff;
   logic [9:0]       lo_ff;
   logic [3:0]       bq_ff;
   logic [HueW-1:0]  h_ff;
   logic [26:0]      ml_ff;
   logic [OutW-1:0]  sc_ff;
   logic [OutW-1:0]  lc_ff;
   logic [HueW-1:0]  hc_ff;
   logic             bigc_ff;
   logic [OutW-1:0]  p_ff;
   logic [OutW-1:0]  q_ff;
   logic [OutW-1:0]  d_ff;
   hue_pos_type [2:0] pos_ff;

   // stage a: bias hue positive, split into 4-degree blocks, block / 90
   always_comb begin
      biased = {hue[ArgW-1], hue} + HueBias;
      bprod  = {15'b0, biased[20:10]} * {11'b0, BlockRecip};
   end

   // stage b: remainder of blocks mod 90 gives hue in one turn
   always_comb begin
      rem_w = blk_ff - ({7'b0, bq_ff} * BlockDeg);
      h_in  = {rem_w[6:0], lo_ff};
   end

   // stage c: lightness product
   always_comb begin
      big  = light_q12 >= HalfQ12;
      mfac = big ? {1'b0, sat_q12} : ({1'b0, sat_q12} + 14'd4096);
      ml   = {14'b0, light_q12} * {13'b0, mfac};
   end

   // stage d: q, p, spread and channel hue positions
   always_comb begin
      rnd_w = ml_ff + 27'd2048;
      rnd   = rnd_w[26:12];
      q_w   = bigc_ff ? ({2'b00, lc_ff} + {2'b00, sc_ff} - rnd) : rnd;
      q_in  = q_w[OutW-1:0];
      p_w   = {lc_ff, 1'b0} - {1'b0, q_in};
      p_in  = p_w[OutW-1:0];
      d_in  = q_in - p_in;
      tch[0] = (hc_ff >= TwoThirds) ? (hc_ff - TwoThirds) : (hc_ff + Third);
      tch[1] = hc_ff;
      tch[2] = (hc_ff < Third) ? (hc_ff + TwoThirds) : (hc_ff - Third);
      for (int k = 0; k < 3; k++) begin
         pos_in[k] = locate(tch[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en.a) begin
         blk_ff <= biased[20:10];
         lo_ff  <= biased[9:0];
         bq_ff  <= bprod[BlockShift +: 4];
      end
      if (en.b) begin
         h_ff <= h_in;
      end
      if (en.c) begin
         ml_ff   <= ml;
         sc_ff   <= sat_q12;
         lc_ff   <= light_q12;
         hc_ff   <= h_ff;
         bigc_ff <= big;
      end
      if (en.d) begin
         p_ff   <= p_in;
         q_ff   <= q_in;
         d_ff   <= d_in;
         pos_ff <= pos_in;
      end
   end

   assign p   = p_ff;
   assign q   = q_ff;
   assign d   = d_ff;
   assign pos = pos_ff;

endmodule

>>> rtl/core/cssc_hue_lerp.sv
// Per-channel HSL interpolation and output select over three stages.
module cssc_hue_lerp (
   input  logic                       clock,
   input  cssc_pkg::pipe_en_type      en,
   input  logic [cssc_pkg::OutW-1:0]  p,
   input  logic [cssc_pkg::OutW-1:0]  q,
   input  logic [cssc_pkg::OutW-1:0]  d,
   input  cssc_pkg::hue_pos_type      pos,
   input  logic                       hsl,
   input  logic [cssc_pkg::OutW-1:0]  rgb,
   output logic [cssc_pkg::OutW-1:0]  value
);
   import cssc_pkg::*;

   logic [25:0]      lp;
   logic [32:0]      zp;
   logic [13:0]      sum;
   logic [13:0]      hv;
   logic [OutW-1:0]  hv_clamp;
   logic [OutW-1:0]  value_in;

   logic [15:0]      y_ff;
   seg_type          seg_e_ff;
   logic [OutW-1:0]  p_e_ff;
   logic [OutW-1:0]  q_e_ff;
   logic [OutW-1:0]  z_ff;
   seg_type          seg_f_ff;
   logic [OutW-1:0]  p_f_ff;
   logic [OutW-1:0]  q_f_ff;
   logic [OutW-1:0]  value_ff;

   // (d*t + 7680) / 15360 as ((... >> 10) / 15)
   assign lp = ({13'b0, d} * {12'b0, pos.frac}) + LerpRound;
   assign zp = {17'b0, y_ff} * {16'b0, FifteenRecip};

   always_comb begin
      sum = {1'b0, p_f_ff} + {1'b0, z_ff};
      unique case (seg_f_ff)
         SEG_RISE, SEG_FALL: hv = sum;
         SEG_HIGH:           hv = {1'b0, q_f_ff};
         SEG_LOW:            hv = {1'b0, p_f_ff};
      endcase
      hv_clamp = (hv > {1'b0, OneQ12}) ? OneQ12 : hv[OutW-1:0];
      value_in = hsl ? hv_clamp : rgb;
   end

   always_ff @(posedge clock) begin
      if (en.e) begin
         y_ff     <= lp[25:10];
         seg_e_ff <= pos.seg;
         p_e_ff   <= p;
         q_e_ff   <= q;
      end
      if (en.f) begin
         z_ff     <= zp[FifteenShift +: OutW];
         seg_f_ff <= seg_e_ff;
         p_f_ff   <= p_e_ff;
         q_f_ff   <= q_e_ff;
      end
      if (en.g) begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

>>> test/tb.sv
// Self-checking testbench for the rgb()/hsl() argument to RGBA converter.
`timescale 1ns / 1ps

module tb;
   import cssc_pkg::*;

   localparam longint Q12One      = 4096;
   localparam longint TurnQ8      = 92160;
   localparam longint SixthQ8     = 15360;
   localparam longint ThirdQ8     = 30720;
   localparam longint HalfTurnQ8  = 46080;
   localparam longint TwoThirdsQ8 = 61440;
   localparam logic   ModeRgb     = 1'b0;
   localparam logic   ModeHsl     = 1'b1;
   localparam int     RandomCalls = 900;
   localparam int     DrainCycles = 30;

   typedef enum int {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_SLOW,
      DRAIN_PERIODIC
   } drain_style_type;

   typedef struct {
      logic                   mode;
      logic signed [ArgW-1:0] first_value;
      logic signed [ArgW-1:0] second_value;
      logic signed [ArgW-1:0] third_value;
      logic signed [ArgW-1:0] alpha_value;
      logic                   first_pct;
      logic                   second_pct;
      logic                   third_pct;
      logic                   alpha_pct;
      logic                   alpha_given;
   } color_call_type;

   typedef struct {
      logic [OutW-1:0] red;
      logic [OutW-1:0] green;
      logic [OutW-1:0] blue;
      logic [OutW-1:0] alpha;
   } rgba_type;

   class color_scoreboard;
      rgba_type pending_colors[$];
      int       errors;

      function new();
         errors = 0;
      endfunction

      static function longint unit_clip(longint x);
         if (x < 0) return 0;
         if (x > Q12One) return Q12One;
         return x;
      endfunction

      static function longint arg_to_q12(longint v, bit pct);
         if (v <= 0) return 0;
         if (pct) return unit_clip((v * 4 + 12) / 25);
         return unit_clip((v * 16 + 127) / 255);
      endfunction

      static function longint hue_ramp(longint p, longint q, longint t);
         longint d;
         longint w;
         d = q - p;
         w = t % TurnQ8;
         if (w < 0) w += TurnQ8;
         if (w < SixthQ8) return p + (d * w + SixthQ8 / 2) / SixthQ8;
         if (w < HalfTurnQ8) return q;
         if (w < TwoThirdsQ8) return p + (d * (TwoThirdsQ8 - w) + SixthQ8 / 2) / SixthQ8;
         return p;
      endfunction

      function void note_call(color_call_type c);
         rgba_type e;
         longint   s;
         longint   l;
         longint   q;
         longint   p;
         longint   h;
         if (!c.alpha_given)
            e.alpha = OutW'(Q12One);
         else if (c.alpha_pct)
            e.alpha = OutW'(arg_to_q12(c.alpha_value, 1'b1));
         else
            e.alpha = OutW'(unit_clip(longint'(c.alpha_value) * 16));

         if (c.mode == ModeRgb) begin
            e.red   = OutW'(arg_to_q12(c.first_value, c.first_pct));
            e.green = OutW'(arg_to_q12(c.second_value, c.second_pct));
            e.blue  = OutW'(arg_to_q12(c.third_value, c.third_pct));
         end else begin
            s = arg_to_q12(c.second_value, 1'b1);
            l = arg_to_q12(c.third_value, 1'b1);
            if (s == 0) begin
               e.red   = OutW'(l);
               e.green = OutW'(l);
               e.blue  = OutW'(l);
            end else begin
               if (l < Q12One / 2)
                  q = (l * (Q12One + s) + Q12One / 2) >>> 12;
               else
                  q = l + s - ((l * s + Q12One / 2) >>> 12);
               p = 2 * l - q;
               h = longint'(c.first_value) % TurnQ8;
               if (h < 0) h += TurnQ8;
               e.red   = OutW'(unit_clip(hue_ramp(p, q, h + ThirdQ8)));
               e.green = OutW'(unit_clip(hue_ramp(p, q, h)));
               e.blue  = OutW'(unit_clip(hue_ramp(p, q, h - ThirdQ8)));
            end
         end
         pending_colors = {pending_colors, e};
      endfunction

      function void check_color(rgba_type got);
         rgba_type e;
         if (pending_colors.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected response transfer: r=%0d g=%0d b=%0d a=%0d",
                        got.red, got.green, got.blue, got.alpha);
            return;
         end
         e = pending_colors.pop_front();
         if (got.red !== e.red || got.green !== e.green ||
             got.blue !== e.blue || got.alpha !== e.alpha) begin
            errors++;
            if (errors <= 10)
               $display("color error: exp r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                        e.red, e.green, e.blue, e.alpha,
                        got.red, got.green, got.blue, got.alpha);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   cssc_req_if req_ch();
   cssc_rsp_if rsp_ch();

   css_color_function_to_rgba dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   color_scoreboard sb = new();
   color_call_type  directed_calls[$];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic void queue_call(color_call_type c);
      directed_calls = {directed_calls, c};
   endfunction

   // flags: {first pct, second pct, third pct, alpha pct, alpha given}
   function automatic color_call_type make_call(logic mode, int a, int b, int c, int al,
                                                logic [4:0] flags);
      color_call_type k;
      k.mode         = mode;
      k.first_value  = ArgW'(a);
      k.second_value = ArgW'(b);
      k.third_value  = ArgW'(c);
      k.alpha_value  = ArgW'(al);
      k.first_pct    = flags[4];
      k.second_pct   = flags[3];
      k.third_pct    = flags[2];
      k.alpha_pct    = flags[1];
      k.alpha_given  = flags[0];
      return k;
   endfunction

   function automatic logic signed [ArgW-1:0] plausible_arg(bit pct);
      if ($urandom_range(0, 15) == 0) return ArgW'(-int'($urandom_range(1, 2000)));
      if (pct) return ArgW'($urandom_range(0, 25600 + 512));
      return ArgW'($urandom_range(0, 65280 + 512));
   endfunction

   function automatic color_call_type random_call();
      color_call_type c;
      c.mode        = 1'($urandom_range(0, 1));
      c.first_pct   = 1'($urandom_range(0, 1));
      c.second_pct  = 1'($urandom_range(0, 1));
      c.third_pct   = 1'($urandom_range(0, 1));
      c.alpha_pct   = 1'($urandom_range(0, 1));
      c.alpha_given = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 7) begin
         if (c.mode == ModeRgb) begin
            c.first_value  = plausible_arg(c.first_pct);
            c.second_value = plausible_arg(c.second_pct);
            c.third_value  = plausible_arg(c.third_pct);
         end else begin
            c.first_value  = ArgW'(int'($urandom_range(0, 368640)) - 184320);
            c.second_value = plausible_arg(1'b1);
            c.third_value  = plausible_arg(1'b1);
         end
         if (c.alpha_pct)
            c.alpha_value = plausible_arg(1'b1);
         else
            c.alpha_value = ArgW'(int'($urandom_range(0, 300)) - 16);
      end else begin
         c.first_value  = ArgW'($urandom());
         c.second_value = ArgW'($urandom());
         c.third_value  = ArgW'($urandom());
         c.alpha_value  = ArgW'($urandom());
      end
      return c;
   endfunction

   task automatic send_call(color_call_type c);
      req_ch.valid             <= 1'b1;
      req_ch.mode              <= c.mode;
      req_ch.first_value       <= c.first_value;
      req_ch.second_value      <= c.second_value;
      req_ch.third_value       <= c.third_value;
      req_ch.alpha_value       <= c.alpha_value;
      req_ch.first_is_percent  <= c.first_pct;
      req_ch.second_is_percent <= c.second_pct;
      req_ch.third_is_percent  <= c.third_pct;
      req_ch.alpha_is_percent  <= c.alpha_pct;
      req_ch.alpha_given       <= c.alpha_given;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // transfer monitor
   always @(posedge clock) begin : watch
      color_call_type seen;
      rgba_type       got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen.mode         = req_ch.mode;
            seen.first_value  = req_ch.first_value;
            seen.second_value = req_ch.second_value;
            seen.third_value  = req_ch.third_value;
            seen.alpha_value  = req_ch.alpha_value;
            seen.first_pct    = req_ch.first_is_percent;
            seen.second_pct   = req_ch.second_is_percent;
            seen.third_pct    = req_ch.third_is_percent;
            seen.alpha_pct    = req_ch.alpha_is_percent;
            seen.alpha_given  = req_ch.alpha_given;
            sb.note_call(seen);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.red   = rsp_ch.red_out;
            got.green = rsp_ch.green_out;
            got.blue  = rsp_ch.blue_out;
            got.alpha = rsp_ch.alpha_out;
            sb.check_color(got);
         end
      end
   end

   initial begin : drain
      drain_style_type style;
      int              span;
      int              tick;
      rsp_ch.ready <= 1'b0;
      tick = 0;
      forever begin
         style = drain_style_type'($urandom_range(0, 3));
         span  = $urandom_range(20, 200);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (style)
               DRAIN_FREE:     rsp_ch.ready <= 1'b1;
               DRAIN_COIN:     rsp_ch.ready <= 1'($urandom_range(0, 1));
               DRAIN_SLOW:     rsp_ch.ready <= ($urandom_range(0, 4) == 0);
               DRAIN_PERIODIC: rsp_ch.ready <= ((tick % 16) < 11);
               default:        rsp_ch.ready <= 1'b1;
            endcase
         end
      end
   end

   initial begin : stimulus
      int burst_left;
      int gap;
      req_ch.valid             <= 1'b0;
      req_ch.mode              <= ModeRgb;
      req_ch.first_value       <= '0;
      req_ch.second_value      <= '0;
      req_ch.third_value       <= '0;
      req_ch.alpha_value       <= '0;
      req_ch.first_is_percent  <= 1'b0;
      req_ch.second_is_percent <= 1'b0;
      req_ch.third_is_percent  <= 1'b0;
      req_ch.alpha_is_percent  <= 1'b0;
      req_ch.alpha_given       <= 1'b0;
      reset = 1'b1;

      queue_call(make_call(ModeRgb, 0, 0, 0, 0, 5'b00000));
      queue_call(make_call(ModeRgb, 524287, 524287, 524287, 25600, 5'b10111));
      queue_call(make_call(ModeRgb, -524288, -524288, -524288, -524288, 5'b00001));
      queue_call(make_call(ModeRgb, 65280, 32640, 25600, 128, 5'b00101));
      queue_call(make_call(ModeRgb, 65287, 65288, 12800, 12800, 5'b00111));
      queue_call(make_call(ModeRgb, 1, -1, 1, 524287, 5'b00101));
      queue_call(make_call(ModeRgb, 25603, 25604, 256, -256, 5'b11011));
      queue_call(make_call(ModeHsl, 0, 0, 12800, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 0, 25600, 12800, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 60 * 256, 25600, 12800, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 120 * 256, 25600, 12800, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 180 * 256, 25600, 12800, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 240 * 256, 25600, 12800, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 300 * 256, 25600, 12800, 0, 5'b00000));
      queue_call(make_call(ModeHsl, -30 * 256, 25600, 6400, 256, 5'b00001));
      queue_call(make_call(ModeHsl, 524287, 12800, 19200, 6400, 5'b00011));
      queue_call(make_call(ModeHsl, -524288, 25600, 25600, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 90 * 256, 25600, 0, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 200 * 256, 15360, 10240, 0, 5'b11100));
      queue_call(make_call(ModeHsl, 45 * 256, -256, -256, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 330 * 256, 524287, 524287, -256, 5'b00011));
      queue_call(make_call(ModeHsl, 359 * 256 + 255, 25600, 25599, 0, 5'b00000));
      queue_call(make_call(ModeHsl, 360 * 256, 1, 12800, 0, 5'b00000));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      burst_left = 0;
      for (int i = 0; i < directed_calls.size() + RandomCalls; i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         if (i < directed_calls.size())
            send_call(directed_calls[i]);
         else
            send_call(random_call());
         burst_left--;
      end
      req_ch.valid <= 1'b0;

      while (sb.pending_colors.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0 && sb.pending_colors.size() == 0)
         $display("css_color_function_to_rgba: match");
      else
         $display("css_color_function_to_rgba: mismatch");
      $finish;
   end

   initial begin : watchdog
      #8_000_000;
      $display("css_color_function_to_rgba: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/cssc_pkg.sv
rtl/core/cssc_if.sv
rtl/core/cssc_arg_scale.sv
rtl/core/cssc_hsl_prep.sv
rtl/core/cssc_hue_lerp.sv
rtl/core/css_color_function_to_rgba.sv
test/tb.sv
